// ===== hw/rtl/sem_pkg.sv =====
`default_nettype none

package sem_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;

    localparam int PIXEL_W        = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int LINE_W         = 2 * PIXEL_W;

    localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = FRAME_WIDTH_W'(64);
    localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = FRAME_HEIGHT_W'(64);
    localparam int MIN_DIM = 3;

    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

endpackage

`default_nettype wire

// ===== hw/rtl/sem_ram.sv =====
`default_nettype none

module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sobel_edge_magnitude_stream.sv =====
`default_nettype none

// 3x3 Sobel edge magnitude on a raster stream of 8-bit grayscale pixels. Each pixel transfer
// (s_tuser = 0) yields the output pixel frame_width + 1 positions back in the stream, once
// that far into the frame; border outputs are 0, interior outputs are |Gx| + |Gy| saturated
// to 255. After the last pixel of a frame, frame_width + 1 drain transfers (s_tuser = 1)
// push out the pending outputs, the final one with m_tlast high; a drain mid-frame gives
// nothing, and a pixel while drains are pending drops them and starts a new frame. One item
// is taken every clock while the output is not stalled; a result passes through the line buffer
// memory read (one read and one write port, registered read) and then the result
// register. Widths below 3 are used as 3 and above MAX_WIDTH as MAX_WIDTH, heights below 3
// as 3. Writing either register restarts the frame; write only while the stream is idle.
module sobel_edge_magnitude_stream #(
    parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEFAULT
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // tdata: pixel[7:0]
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [sem_pkg::PIXEL_W-1:0]     s_tdata,
    // tuser: command[0]
    input  wire logic                            s_tuser,
    // tdata: edge_value[7:0]
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [sem_pkg::PIXEL_W-1:0]     m_tdata,
    output logic                                 m_tlast,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sem_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [sem_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [sem_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready
);

    import sem_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);

    logic [FRAME_WIDTH_W-1:0]  frame_width_reg;
    logic [FRAME_HEIGHT_W-1:0] frame_height_reg;
    logic [WW-1:0]             eff_w;
    logic [FRAME_HEIGHT_W-1:0] eff_h;
    logic                      cfg_wr;

    logic [CW-1:0]             col_reg;
    logic [FRAME_HEIGHT_W-1:0] row_reg;
    logic [PW-1:0]             pend_reg;

    logic                      in_acc;
    logic                      in_pixel;
    logic                      col_end;
    logic                      row_end;
    logic [WW-1:0]             col_plus;
    logic [FRAME_HEIGHT_W:0]   row_plus;

    logic                      a_valid_reg;
    logic                      a_emit_reg;
    logic                      a_pixel_op_reg;
    logic                      a_interior_reg;
    logic                      a_last_reg;
    logic [PIXEL_W-1:0]        a_pixel_reg;
    logic [CW-1:0]             a_col_reg;
    logic                      a_adv;

    logic [PIXEL_W-1:0]        win_reg [6];
    logic [LINE_W-1:0]         line_rd;
    logic [PIXEL_W-1:0]        nt;
    logic [PIXEL_W-1:0]        nm;
    logic [PIXEL_W-1:0]        nb;
    logic [PIXEL_W+1:0]        gx_pos;
    logic [PIXEL_W+1:0]        gx_neg;
    logic [PIXEL_W+1:0]        gy_pos;
    logic [PIXEL_W+1:0]        gy_neg;
    logic signed [PIXEL_W+2:0] gx;
    logic signed [PIXEL_W+2:0] gy;
    logic [PIXEL_W+1:0]        gx_abs;
    logic [PIXEL_W+1:0]        gy_abs;
    logic [PIXEL_W+2:0]        mag;
    logic [PIXEL_W-1:0]        edge_val;

    logic                      m_valid_reg;
    logic [PIXEL_W-1:0]        m_data_reg;
    logic                      m_last_reg;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RESET;
            frame_height_reg <= FRAME_HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_FRAME_WIDTH:  frame_width_reg  <= pwdata[FRAME_WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= pwdata[FRAME_HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            CFG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            CFG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        if (32'(frame_width_reg) < MIN_DIM) begin
            eff_w = WW'(MIN_DIM);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(frame_width_reg);
        end
        if (32'(frame_height_reg) < MIN_DIM) begin
            eff_h = FRAME_HEIGHT_W'(MIN_DIM);
        end else begin
            eff_h = frame_height_reg;
        end
    end

    // input side: position and drain bookkeeping at transfer time
    assign a_adv    = a_valid_reg && (!a_emit_reg || !m_valid_reg || m_tready);
    assign s_tready = !a_valid_reg || a_adv;
    assign in_acc   = s_tvalid && s_tready;
    assign in_pixel = (s_tuser == CMD_PIXEL);
    assign col_plus = WW'(col_reg) + WW'(1);
    assign row_plus = {1'b0, row_reg} + (FRAME_HEIGHT_W + 1)'(1);
    assign col_end  = (col_plus == eff_w);
    assign row_end  = (row_plus == {1'b0, eff_h});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (cfg_wr) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (in_acc) begin
            if (in_pixel) begin
                pend_reg <= '0;
                if (col_end) begin
                    col_reg <= '0;
                    if (row_end) begin
                        row_reg  <= '0;
                        pend_reg <= PW'(eff_w) + PW'(1);
                    end else begin
                        row_reg <= row_plus[FRAME_HEIGHT_W-1:0];
                    end
                end else begin
                    col_reg <= col_plus[CW-1:0];
                end
            end else if (pend_reg != '0) begin
                pend_reg <= pend_reg - PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (in_acc) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            a_pixel_op_reg <= in_pixel;
            a_pixel_reg    <= s_tdata;
            a_col_reg      <= col_reg;
            a_interior_reg <= in_pixel && (row_reg >= FRAME_HEIGHT_W'(2))
                              && (32'(col_reg) >= 2);
            if (in_pixel) begin
                a_emit_reg <= (row_reg >= FRAME_HEIGHT_W'(2))
                              || ((row_reg == FRAME_HEIGHT_W'(1)) && (col_reg != '0));
                a_last_reg <= 1'b0;
            end else begin
                a_emit_reg <= (pend_reg != '0);
                a_last_reg <= (pend_reg == PW'(1));
            end
        end
    end

    // line buffers: high byte two rows up, low byte one row up
    sem_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (a_adv && a_pixel_op_reg),
        .wr_addr (a_col_reg),
        .wr_data ({nm, nb}),
        .rd_en   (in_acc),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    // kernel
    assign nt = line_rd[LINE_W-1:PIXEL_W];
    assign nm = line_rd[PIXEL_W-1:0];
    assign nb = a_pixel_reg;

    assign gx_pos = {2'b00, nt} + {1'b0, nm, 1'b0} + {2'b00, nb};
    assign gx_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[1], 1'b0} + {2'b00, win_reg[2]};
    assign gy_pos = {2'b00, win_reg[2]} + {1'b0, win_reg[5], 1'b0} + {2'b00, nb};
    assign gy_neg = {2'b00, win_reg[0]} + {1'b0, win_reg[3], 1'b0} + {2'b00, nt};
    assign gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    assign gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
    assign gx_abs = gx[PIXEL_W+2] ? (PIXEL_W + 2)'(0) - gx[PIXEL_W+1:0] : gx[PIXEL_W+1:0];
    assign gy_abs = gy[PIXEL_W+2] ? (PIXEL_W + 2)'(0) - gy[PIXEL_W+1:0] : gy[PIXEL_W+1:0];
    assign mag    = {1'b0, gx_abs} + {1'b0, gy_abs};

    always_comb begin
        if (!a_interior_reg) begin
            edge_val = '0;
        end else if (mag > (PIXEL_W + 3)'(255)) begin
            edge_val = '1;
        end else begin
            edge_val = mag[PIXEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (a_adv && a_pixel_op_reg) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= nt;
            win_reg[4] <= nm;
            win_reg[5] <= nb;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (a_adv && a_emit_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv && a_emit_reg) begin
            m_data_reg <= edge_val;
            m_last_reg <= a_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // checks
    a_last_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("frame end transfer carries a nonzero edge value");

    a_pend_at_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != '0 |-> col_reg == '0 && row_reg == '0)
        else $error("drain outputs pending away from frame start");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        WW'(col_reg) < eff_w)
        else $error("column counter beyond frame width");

    a_last_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        a_valid_reg && a_last_reg |-> !a_pixel_op_reg && a_emit_reg)
        else $error("frame end marked on a pixel item");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import sem_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEFAULT;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 800;

    typedef struct packed {
        logic [PIXEL_W-1:0] magnitude;
        logic               frame_end;
    } edge_result_t;

    typedef struct packed {
        logic               cmd;
        logic [PIXEL_W-1:0] px;
        logic               given;
        logic               has;
        logic [PIXEL_W-1:0] magnitude;
        logic               frame_end;
    } directed_row_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata  = '0;
    logic                  s_tuser  = CMD_PIXEL;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    sobel_edge_magnitude_stream #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [FRAME_WIDTH_W-1:0]  cfg_width;
    logic [FRAME_HEIGHT_W-1:0] cfg_height;
    logic [LINE_W-1:0]         line_mem [MAX_W];
    logic [PIXEL_W-1:0]        win [6];
    int unsigned               col_pos;
    int unsigned               row_pos;
    int unsigned               drains_left;

    edge_result_t pending_edges [$];
    int           error_count   = 0;
    int           cycle_count   = 0;
    int           random_pixels = 0;
    int           rx_hold       = 0;
    bit           src_idle_on   = 1'b1;
    bit           rx_idle_on    = 1'b1;

    // 3x3 frames: a vertical step that saturates, then mixed values
    directed_row_t directed_rows [26] = '{
        '{CMD_PIXEL, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd100, 1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd255, 1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_DRAIN, 8'hA5,  1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd0,   1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd100, 1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd255, 1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd0,   1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd100, 1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd255, 1'b1, 1'b1, 8'd255, 1'b0},
        '{CMD_DRAIN, 8'h00,  1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_DRAIN, 8'h00,  1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_DRAIN, 8'h00,  1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_DRAIN, 8'h00,  1'b1, 1'b1, 8'd0,   1'b1},
        '{CMD_DRAIN, 8'hFF,  1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd10,  1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd200, 1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd30,  1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd40,  1'b1, 1'b0, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd5,   1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd250, 1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd255, 1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd0,   1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_PIXEL, 8'd77,  1'b0, 1'b0, 8'd0,   1'b0},
        '{CMD_DRAIN, 8'h00,  1'b1, 1'b1, 8'd0,   1'b0},
        '{CMD_DRAIN, 8'h00,  1'b1, 1'b1, 8'd0,   1'b0}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string field, input int unsigned want,
                                   input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    function automatic int unsigned used_width();
        if (cfg_width < MIN_DIM) return MIN_DIM;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height < MIN_DIM) return MIN_DIM;
        return cfg_height;
    endfunction

    task automatic restart_position();
        col_pos     = 0;
        row_pos     = 0;
        drains_left = 0;
    endtask

    task automatic sobel_reset_state();
        cfg_width  = FRAME_WIDTH_RESET;
        cfg_height = FRAME_HEIGHT_RESET;
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (win[i]) win[i] = '0;
        restart_position();
    endtask

    task automatic sobel_predict(input logic cmd, input logic [PIXEL_W-1:0] px,
                                 output bit has, output edge_result_t res);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        logic [PIXEL_W-1:0] nt;
        logic [PIXEL_W-1:0] nm;
        int                 gx;
        int                 gy;
        int                 mag;
        w   = used_width();
        h   = used_height();
        has = 1'b0;
        res = '0;
        if (cmd == CMD_DRAIN) begin
            if (drains_left != 0) begin
                drains_left--;
                has           = 1'b1;
                res.frame_end = (drains_left == 0);
            end
        end else begin
            drains_left = 0;
            if (col_pos >= w) col_pos = 0;
            if (row_pos >= h) row_pos = 0;
            c = col_pos;
            r = row_pos;
            {nt, nm}    = line_mem[c];
            line_mem[c] = {nm, px};
            if (r >= 2 || (r == 1 && c >= 1)) begin
                has = 1'b1;
                if (r >= 2 && c >= 2) begin
                    gx = (int'(nt) + 2 * int'(nm) + int'(px))
                       - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
                    gy = (int'(win[2]) + 2 * int'(win[5]) + int'(px))
                       - (int'(win[0]) + 2 * int'(win[3]) + int'(nt));
                    mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                    res.magnitude = (mag > 255) ? 8'hFF : 8'(mag);
                end
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = nt;
            win[4] = nm;
            win[5] = px;
            if (c + 1 >= w) begin
                col_pos = 0;
                if (r + 1 >= h) begin
                    row_pos     = 0;
                    drains_left = w + 1;
                end else begin
                    row_pos = r + 1;
                end
            end else begin
                col_pos = c + 1;
            end
        end
    endtask

    task automatic write_register(input logic idx, input logic [APB_DATA_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) begin
            cfg_width = value[FRAME_WIDTH_W-1:0];
        end else begin
            cfg_height = value[FRAME_HEIGHT_W-1:0];
        end
        restart_position();
    endtask

    task automatic send_item(input logic cmd, input logic [PIXEL_W-1:0] px,
                             input logic given, input logic given_has,
                             input edge_result_t given_res);
        int           gap;
        bit           has;
        edge_result_t res;
        gap = src_idle_on ? $urandom_range(0, 9) : 0;
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        sobel_predict(cmd, px, has, res);
        if (given) begin
            has = given_has;
            res = given_res;
        end
        if (has) pending_edges.push_back(res);
    endtask

    task automatic hold_stream();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge aclk);
    endtask

    task automatic wait_idle();
        hold_stream();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_frame(input int unsigned w, input int unsigned h, input bit pause_mid);
        int                 style;
        int unsigned        n;
        int unsigned        drains;
        logic [PIXEL_W-1:0] px;
        style = $urandom_range(0, 3);
        n     = w * h;
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 39) == 0) send_item(CMD_DRAIN, 8'($urandom), 0, 0, '0);
            if (pause_mid && i == n / 2) hold_stream();
            case (style)
                0: px = 8'($urandom);
                1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                2: px = 8'($urandom_range(120, 136));
                default: px = {$urandom_range(0, 1) ? 4'hF : 4'h0, 4'($urandom)};
            endcase
            send_item(CMD_PIXEL, px, 0, 0, '0);
            random_pixels++;
        end
        case ($urandom_range(0, 9))
            0: drains = $urandom_range(0, w);
            1: drains = w + 1 + $urandom_range(1, 3);
            default: drains = w + 1;
        endcase
        repeat (drains) send_item(CMD_DRAIN, 8'($urandom), 0, 0, '0);
    endtask

    task automatic run_phase(input logic [APB_DATA_W-1:0] width_val,
                             input logic [APB_DATA_W-1:0] height_val,
                             input int frames, input int partial, input bit pressure);
        wait_idle();
        write_register(CFG_FRAME_WIDTH, width_val);
        write_register(CFG_FRAME_HEIGHT, height_val);
        src_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on  = $urandom_range(0, 3) != 0;
        if (pressure) begin
            src_idle_on = 1'b0;
            rx_hold     = 300;
        end
        for (int f = 0; f < frames; f++) send_frame(used_width(), used_height(), pressure && f == 0);
        repeat (partial) begin
            send_item(CMD_PIXEL, 8'($urandom), 0, 0, '0);
            random_pixels++;
        end
    endtask

    initial begin : result_sink
        int           gap;
        edge_result_t want;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold != 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end else begin
                gap = rx_idle_on ? $urandom_range(0, 9) : 0;
            end
            @(negedge aclk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            if (pending_edges.size() == 0) begin
                report_mismatch("unexpected transfer, edge value", 0, m_tdata);
            end else begin
                want = pending_edges.pop_front();
                if (m_tdata !== want.magnitude) begin
                    report_mismatch("edge value", want.magnitude, m_tdata);
                end
                if (m_tlast !== want.frame_end) begin
                    report_mismatch("tlast", want.frame_end, m_tlast);
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned w;
        int          phase;
        sobel_reset_state();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_register(CFG_FRAME_WIDTH, 3);
        write_register(CFG_FRAME_HEIGHT, 3);
        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].cmd, directed_rows[i].px, directed_rows[i].given,
                      directed_rows[i].has,
                      '{directed_rows[i].magnitude, directed_rows[i].frame_end});
        end

        // clamped sizes, widest line, tallest frame cut short
        run_phase(0, 0, 2, 0, 1'b0);
        run_phase(2, 1, 1, 0, 1'b0);
        run_phase(2047, 3, 0, 1040, 1'b0);
        run_phase(3, 65535, 0, 50, 1'b0);

        random_pixels = 0;
        phase         = 0;
        while (random_pixels < RANDOM_PIXELS) begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) : $urandom_range(3, 16);
            run_phase(w, $urandom_range(3, 8), $urandom_range(1, 3),
                      (phase % 5 == 4) ? $urandom_range(1, 2 * w) : 0, phase == 0);
            phase++;
        end
        wait_idle();

        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
